/* design/rgb_kernel_convolution_clamp_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the RGB kernel convolution unit
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_KERNEL_CONVOLUTION_CLAMP_UNIT_ASSERT_SVH
`define RGB_KERNEL_CONVOLUTION_CLAMP_UNIT_ASSERT_SVH

// A property that must hold at every clock edge.
`define RKC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RKC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rkc_pkg.sv */
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared constants, codes and kernel coefficients of the convolution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rkc_pkg;

  localparam int PIX_W = 8;
  localparam int RGB_W = 3 * PIX_W;
  localparam int SUM_W = 20;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int HEIGHT_LIMIT = 4096;

  // Kernel selector codes
  localparam logic [1:0] SEL_CONTRAST = 2'd0;
  localparam logic [1:0] SEL_SOBEL_X  = 2'd1;
  localparam logic [1:0] SEL_SOBEL_Y  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Per-item flags handed from the front part to the back part.
  typedef struct packed {
    logic emit;
    logic frame_done;
  } rkc_tag_t;

  typedef logic signed [5:0] coef_t;

  localparam coef_t K9 [9][9] = '{
    '{ 0, 0, 0,-1,-1,-1, 0, 0, 0},
    '{ 0,-2,-3,-3,-3,-3,-3,-2, 0},
    '{ 0,-3,-2,-1,-1,-1,-2,-3, 0},
    '{-1,-3,-1, 9, 9, 9,-1,-3,-1},
    '{-1,-3,-1, 9,19, 9,-1,-3,-1},
    '{-1,-3,-1, 9, 9, 9,-1,-3,-1},
    '{ 0,-3,-2,-1,-1,-1,-2,-3, 0},
    '{ 0,-2,-3,-3,-3,-3,-3,-2, 0},
    '{ 0, 0, 0,-1,-1,-1, 0, 0, 0}
  };

  localparam coef_t SX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam coef_t SY [3][3] = '{'{ 1, 2, 1}, '{ 0, 0, 0}, '{-1,-2,-1}};

  // Coefficient of a window tap; taps outside the active kernel weigh zero.
  function automatic coef_t coef(input logic [1:0] sel, input int i, input int j);
    coef_t res;
    res = '0;
    if (sel == SEL_CONTRAST) begin
      if (i < 9 && j < 9) res = K9[i][j];
    end else if (sel == SEL_SOBEL_X) begin
      if (i < 3 && j < 3) res = SX[i][j];
    end else begin
      if (i < 3 && j < 3) res = SY[i][j];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/rkc_front.sv */
// ----------------------------------------------------------------------------
// rkc_front
// Tracks the raster position of each input pixel and decides whether it
// closes a complete window, then hands the pixel on to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_TAPS  = 9,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [1:0]              sel_i,
  input  wire logic [11:0]             width_i,
  input  wire logic [12:0]             height_i,
  input  wire logic                    acc_i,
  output logic                         push_o,
  output logic [CW-1:0]                col_o,
  output rkc_pkg::rkc_tag_t            tag_o
);
  import rkc_pkg::*;

  localparam logic [13:0] MaxW = 14'(MAX_WIDTH);
  localparam logic [13:0] MaxH = 14'(HEIGHT_LIMIT);

  logic [CW-1:0] col_q, col_d;
  logic [11:0]   row_q, row_d;
  logic [13:0]   w_eff, h_eff, c_ext, r_ext, k_ext;
  logic          k_ok;
  logic [CW-1:0] c_use;

  // Effective frame size and kernel span
  always_comb begin
    w_eff = ({2'b0, width_i} > MaxW) ? MaxW : {2'b0, width_i};
    if (w_eff == '0) w_eff = 14'd1;
    h_eff = ({1'b0, height_i} > MaxH) ? MaxH : {1'b0, height_i};
    if (h_eff == '0) h_eff = 14'd1;
    k_ext = (sel_i == SEL_CONTRAST) ? 14'd9 : 14'd3;
    k_ok  = (sel_i != SEL_CONTRAST) || (MAX_TAPS >= 9);
    c_use = col_q;
    c_ext = 14'(c_use);
    r_ext = 14'(row_q);
  end

  // Classification of the current pixel
  always_comb begin
    push_o           = acc_i && k_ok;
    col_o            = c_use;
    tag_o.emit       = (r_ext + 14'd1 >= k_ext) && (c_ext + 14'd1 >= k_ext)
                    && (r_ext + 14'd2 <= h_eff) && (c_ext + 14'd2 <= w_eff);
    tag_o.frame_done = (r_ext + 14'd2 == h_eff) && (c_ext + 14'd2 == w_eff);
  end

  // Raster position advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (c_ext + 14'd1 >= w_eff) begin
        col_d = '0;
        if (r_ext + 14'd1 >= h_eff) row_d = '0;
        else row_d = row_q + 12'd1;
      end else begin
        col_d = c_use + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

/* design/rkc_fifo.sv */
// ----------------------------------------------------------------------------
// rkc_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_kernel_convolution_clamp_unit_assert.svh"

module rkc_fifo #(
  parameter int WIDTH = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);
  localparam int Depth = 4;
  localparam int PW = $clog2(Depth);
  localparam logic [PW:0] DepthCnt = (PW+1)'(Depth);

  logic [WIDTH-1:0] slot_q [Depth];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Occupancy count
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wp_q] <= data_i;
  end

  `RKC_ASSERT(a_cnt_bound, cnt_q <= DepthCnt, "queue count beyond depth")
  `RKC_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "count missed push")
  `RKC_ASSERT(a_ptr_gap, (wp_q - rp_q) == cnt_q[PW-1:0], "pointers disagree with count")

endmodule

`default_nettype wire

/* design/rkc_back.sv */
// ----------------------------------------------------------------------------
// rkc_back
// Line buffers, sliding window, weighted sums, clamping and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_TAPS  = 9,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [1:0]                sel_i,
  input  wire logic                      empty_i,
  input  wire logic [CW-1:0]             col_i,
  input  wire rkc_pkg::rkc_tag_t         tag_i,
  input  wire logic [rkc_pkg::RGB_W-1:0] pix_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [rkc_pkg::RGB_W-1:0]      out_data_o,
  output logic                           out_last_o
);
  import rkc_pkg::*;

  localparam int NT = MAX_TAPS;
  localparam int LW = RGB_W * (NT - 1);

  logic adv, k9;

  // Line store: one row per column, holding the previous rows side by side
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_q;

  // Stage one: item just read from the queue
  logic           v1_q;
  logic [CW-1:0]  col1_q;
  rkc_tag_t       tag1_q;
  logic [RGB_W-1:0] pix1_q;
  logic           wv_q;
  logic [CW-1:0]  wcol_q;
  logic [LW-1:0]  wdat_q;
  logic [LW-1:0]  line1, line_new;
  logic [RGB_W-1:0] colv [NT];

  // Window and sum stages
  logic [RGB_W-1:0] win_q [NT][NT];
  logic             v2_q, fd2_q, v3_q, fd3_q, v4_q, fd4_q;
  logic signed [SUM_W-1:0] rs_q [3][NT];
  logic signed [SUM_W-1:0] rs_d [3][NT];
  logic signed [SUM_W-1:0] tot_q [3];
  logic signed [SUM_W-1:0] tot_d [3];
  logic [RGB_W-1:0] clamp_d;
  logic             ov_q;

  assign k9    = (sel_i == SEL_CONTRAST);
  assign adv   = !(ov_q && !out_ready_i);
  assign pop_o = adv && !empty_i;

  // Queue read and line store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      wv_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !empty_i;
      wv_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q   <= line_mem[col_i];
      col1_q <= col_i;
      tag1_q <= tag_i;
      pix1_q <= pix_i;
      wcol_q <= col1_q;
      wdat_q <= line_new;
      if (v1_q) line_mem[col1_q] <= line_new;
    end
  end

  // Forward the previous write when it hit the same column
  always_comb begin
    line1    = (wv_q && wcol_q == col1_q) ? wdat_q : rd_q;
    line_new = {line1[LW-RGB_W-1:0], pix1_q};
  end

  // New window column, oldest row first
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      colv[i] = '0;
      if (k9) begin
        if (i == NT - 1) colv[i] = pix1_q;
        else colv[i] = line1[RGB_W*(NT-2-i) +: RGB_W];
      end else if (i == 0) begin
        colv[i] = line1[RGB_W +: RGB_W];
      end else if (i == 1) begin
        colv[i] = line1[0 +: RGB_W];
      end else if (i == 2) begin
        colv[i] = pix1_q;
      end
    end
  end

  // Window shift
  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      for (int i = 0; i < NT; i++) begin
        if (k9) begin
          for (int j = 0; j < NT - 1; j++) win_q[i][j] <= win_q[i][j+1];
          win_q[i][NT-1] <= colv[i];
        end else if (i < 3) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
          win_q[i][2] <= colv[i];
        end
      end
    end
  end

  // Row sums of weighted taps; taps outside a 3x3 kernel are left out
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < NT; i++) begin
        rs_d[c][i] = '0;
        for (int j = 0; j < NT; j++) begin
          if (k9 || (i < 3 && j < 3)) begin
            rs_d[c][i] = rs_d[c][i]
              + SUM_W'($signed({1'b0, win_q[i][j][PIX_W*c +: PIX_W]}))
              * SUM_W'(coef(sel_i, i, j));
          end
        end
      end
    end
  end

  // Column of row sums into one total per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot_d[c] = '0;
      for (int i = 0; i < NT; i++) tot_d[c] = tot_d[c] + rs_q[c][i];
    end
  end

  // Clamp to a byte
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (tot_q[c] < 0) clamp_d[PIX_W*c +: PIX_W] = '0;
      else if (tot_q[c] > SUM_W'(255)) clamp_d[PIX_W*c +: PIX_W] = 8'hFF;
      else clamp_d[PIX_W*c +: PIX_W] = tot_q[c][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q && tag1_q.emit;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fd2_q      <= tag1_q.frame_done;
      rs_q       <= rs_d;
      fd3_q      <= fd2_q;
      tot_q      <= tot_d;
      fd4_q      <= fd3_q;
      out_data_o <= clamp_d;
      out_last_o <= fd4_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule

`default_nettype wire

/* design/rgb_kernel_convolution_clamp_unit.sv */
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_clamp_unit
// Streaming RGB convolution with a 9x9 contrast or 3x3 Sobel kernel and
// byte clamping of every channel.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         tdata = red, green, blue
//  m_axis   out        tdata = red, green, blue; tlast = frame done
//  cfg      in         cfg_idx_i selects kernel, width or height
//
// One pixel is accepted per clock while the queue is not full. The line store
// read, window shift, row sums, total and clamp each take one register stage
// after the pixel that completes its window. A stalled output holds the whole
// back pipeline; the four-entry queue absorbs up to four more transfers
// before the input stalls. Reset clears the raster position and loads the
// default setup.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_kernel_convolution_clamp_unit #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_TAPS  = 9
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // in_red, in_green, in_blue
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [23:0]                        m_axis_tdata,  // out_red, out_green, out_blue
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic [rkc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rkc_pkg::CFG_W-1:0]     cfg_data_i
);
  import rkc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(rkc_tag_t) + RGB_W;

  logic [1:0]  ksel_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  sel;
  logic        acc, push, full, empty, pop;
  logic [CW-1:0] fcol, qcol;
  rkc_tag_t    ftag, qtag;
  logic [QW-1:0] qin, qout;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q   <= SEL_CONTRAST;
      width_q  <= 12'd1920;
      height_q <= 13'd1080;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KERNEL: ksel_q   <= cfg_data_i[1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[11:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Selector three behaves as Sobel y
  assign sel = (ksel_q > SEL_SOBEL_Y) ? SEL_SOBEL_Y : ksel_q;

  assign s_axis_tready = !full;
  assign acc = s_axis_tvalid && s_axis_tready;

  rkc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_TAPS(MAX_TAPS)) u_front (
    .clk_i, .rst_ni,
    .sel_i(sel), .width_i(width_q), .height_i(height_q),
    .acc_i(acc), .push_o(push), .col_o(fcol), .tag_o(ftag)
  );

  assign qin = {fcol, ftag, s_axis_tdata};

  rkc_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(qin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qout)
  );

  assign qcol = qout[QW-1 -: CW];
  assign qtag = qout[RGB_W +: $bits(rkc_tag_t)];

  rkc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_TAPS(MAX_TAPS)) u_back (
    .clk_i, .rst_ni,
    .sel_i(sel), .empty_i(empty), .col_i(qcol), .tag_i(qtag),
    .pix_i(qout[RGB_W-1:0]), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

endmodule

`default_nettype wire

/* bench/rkc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rkc_checker
// Watches the pixel, result and setup channels of the convolution unit,
// predicts every output pixel from its own copy of the line store, window
// and raster position, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_valid_i,
  input  wire logic                          s_ready_i,
  input  wire logic [23:0]                   s_data_i,   // in_red, in_green, in_blue
  input  wire logic                          m_valid_i,
  input  wire logic                          m_ready_i,
  input  wire logic [23:0]                   m_data_i,   // out_red, out_green, out_blue
  input  wire logic                          m_last_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rkc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rkc_pkg::CFG_W-1:0]     cfg_data_i,
  output int                                 pending_o,
  output int                                 errors_o
);

  localparam int LINE_DEPTH = 8;
  localparam int WIN_DIM    = 9;

  localparam int CONTRAST [9][9] = '{
    '{ 0, 0, 0,-1,-1,-1, 0, 0, 0},
    '{ 0,-2,-3,-3,-3,-3,-3,-2, 0},
    '{ 0,-3,-2,-1,-1,-1,-2,-3, 0},
    '{-1,-3,-1, 9, 9, 9,-1,-3,-1},
    '{-1,-3,-1, 9,19, 9,-1,-3,-1},
    '{-1,-3,-1, 9, 9, 9,-1,-3,-1},
    '{ 0,-3,-2,-1,-1,-1,-2,-3, 0},
    '{ 0,-2,-3,-3,-3,-3,-3,-2, 0},
    '{ 0, 0, 0,-1,-1,-1, 0, 0, 0}
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
  } out_pixel_t;

  out_pixel_t  awaited_pixels [$];
  logic [23:0] line_mem [LINE_DEPTH * 2048];
  logic [23:0] window [WIN_DIM * WIN_DIM];
  logic [1:0]  kernel_sel;
  logic [11:0] width_cfg;
  logic [12:0] height_cfg;
  int          col_pos;
  int          row_pos;
  int          errors;

  assign pending_o = awaited_pixels.size();
  assign errors_o  = errors;

  initial begin
    errors = 0;
    for (int n = 0; n < LINE_DEPTH * 2048; n++) line_mem[n] = '0;
    for (int n = 0; n < WIN_DIM * WIN_DIM; n++) window[n] = '0;
  end

  // Tap weight of the selected kernel.
  function automatic int weight(input logic [1:0] sel, input int i, input int j);
    if (sel == rkc_pkg::SEL_CONTRAST) return CONTRAST[i][j];
    if (sel == rkc_pkg::SEL_SOBEL_X) return (j - 1) * ((i == 1) ? 2 : 1);
    return (1 - i) * ((j == 1) ? 2 : 1);
  endfunction

  // Weighted window sum of one channel, clamped to a byte.
  function automatic logic [7:0] channel_sum(input logic [1:0] sel, input int k,
                                             input int shift);
    int acc;
    acc = 0;
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++)
        acc += int'((window[i * WIN_DIM + j] >> shift) & 24'hFF) * weight(sel, i, j);
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Advance the line store, window and raster position by one pixel.
  task automatic convolve_pixel(input logic [23:0] pix);
    logic [1:0]  sel;
    int          k, w, h, c, r, base;
    logic [23:0] column [WIN_DIM];
    out_pixel_t  res;
    sel = (kernel_sel > rkc_pkg::SEL_SOBEL_Y) ? rkc_pkg::SEL_SOBEL_Y : kernel_sel;
    k = (sel == rkc_pkg::SEL_CONTRAST) ? 9 : 3;
    w = (width_cfg > 2048) ? 2048 : ((width_cfg == 0) ? 1 : int'(width_cfg));
    h = (height_cfg > rkc_pkg::HEIGHT_LIMIT) ? rkc_pkg::HEIGHT_LIMIT :
        ((height_cfg == 0) ? 1 : int'(height_cfg));
    c = (col_pos >= 2048) ? 0 : col_pos;
    r = row_pos;
    base = c * LINE_DEPTH;
    column[k - 1] = pix;
    for (int d = 1; d < k; d++) column[k - 1 - d] = line_mem[base + d - 1];
    for (int d = k - 1; d >= 2; d--) line_mem[base + d - 1] = line_mem[base + d - 2];
    line_mem[base] = pix;
    for (int i = 0; i < k; i++) begin
      for (int j = 0; j + 1 < k; j++)
        window[i * WIN_DIM + j] = window[i * WIN_DIM + j + 1];
      window[i * WIN_DIM + k - 1] = column[i];
    end
    if (r + 1 >= k && c + 1 >= k && r + 2 <= h && c + 2 <= w) begin
      res.red        = channel_sum(sel, k, 0);
      res.green      = channel_sum(sel, k, 8);
      res.blue       = channel_sum(sel, k, 16);
      res.frame_done = (r + 2 == h && c + 2 == w);
      awaited_pixels.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic compare_result();
    out_pixel_t exp_pix;
    if (awaited_pixels.size() == 0) begin
      report($sformatf("unexpected result %h", m_data_i));
      return;
    end
    exp_pix = awaited_pixels.pop_front();
    if (m_data_i[7:0] !== exp_pix.red)
      report($sformatf("red %h, expected %h", m_data_i[7:0], exp_pix.red));
    if (m_data_i[15:8] !== exp_pix.green)
      report($sformatf("green %h, expected %h", m_data_i[15:8], exp_pix.green));
    if (m_data_i[23:16] !== exp_pix.blue)
      report($sformatf("blue %h, expected %h", m_data_i[23:16], exp_pix.blue));
    if (m_last_i !== exp_pix.frame_done)
      report($sformatf("frame done %b, expected %b", m_last_i, exp_pix.frame_done));
  endtask

  // Everything is sampled on the rising edge, before the block updates.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_sel = rkc_pkg::SEL_CONTRAST;
      width_cfg  = 12'd1920;
      height_cfg = 13'd1080;
      col_pos    = 0;
      row_pos    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rkc_pkg::CFG_KERNEL: kernel_sel = cfg_data_i[1:0];
          rkc_pkg::CFG_WIDTH:  width_cfg  = cfg_data_i[11:0];
          rkc_pkg::CFG_HEIGHT: height_cfg = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) convolve_pixel(s_data_i);
      if (m_valid_i && m_ready_i) compare_result();
    end
  end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams whole frames through the convolution unit under several kernel and
// size setups, with random gaps and stalls on both channels, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam logic [1:0] SEL_ALIAS_Y = 2'd3;

  // Pixel content styles of a frame.
  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_WHITE, FILL_BLACK} fill_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          cfg_we_i = 1'b0;
  logic [rkc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [rkc_pkg::CFG_W-1:0]     cfg_data_i = '0;
  int                            pending;
  int                            errors;
  bit                            quiet = 1'b0;
  int                            hold_requests = 0;
  int                            random_pixels = 0;

  always #5 clk_i = ~clk_i;

  rgb_kernel_convolution_clamp_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  rkc_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int hold;
    int served;
    hold = 0;
    served = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && served < hold_requests) begin
        served++;
        hold = 600;
      end else if (hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 15);
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [rkc_pkg::CFG_IDX_W-1:0] idx,
                           input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[rkc_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // One pixel transfer, with an optional gap ahead of it.
  task automatic send_pixel(input logic [23:0] pix);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] make_pixel(input fill_t fill);
    logic [23:0] pix;
    pix = 24'($urandom);
    case (fill)
      FILL_EXTREME:
        for (int n = 0; n < 3; n++) pix[n*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      FILL_WHITE: pix = '1;
      FILL_BLACK: pix = '0;
      default: ;
    endcase
    return pix;
  endfunction

  // Set up the unit, stream a whole frame (or the given count) and drain.
  task automatic run_frame(input logic [1:0] kern, input int w, input int h,
                           input fill_t fill, input int count);
    int weff, heff, n;
    weff = (w > 2048) ? 2048 : ((w == 0) ? 1 : w);
    heff = (h > rkc_pkg::HEIGHT_LIMIT) ? rkc_pkg::HEIGHT_LIMIT : ((h == 0) ? 1 : h);
    n = (count > 0) ? count : weff * heff;
    write_reg(rkc_pkg::CFG_KERNEL, kern);
    write_reg(rkc_pkg::CFG_WIDTH, w);
    write_reg(rkc_pkg::CFG_HEIGHT, h);
    for (int p = 0; p < n; p++) send_pixel(make_pixel(fill));
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin
    int w, h;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest frames for every kernel and pixel style.
    run_frame(rkc_pkg::SEL_CONTRAST, 10, 10, FILL_RANDOM, 0);
    run_frame(rkc_pkg::SEL_CONTRAST, 10, 10, FILL_WHITE, 0);
    run_frame(rkc_pkg::SEL_SOBEL_X, 10, 10, FILL_EXTREME, 0);
    run_frame(rkc_pkg::SEL_SOBEL_Y, 10, 10, FILL_BLACK, 0);
    run_frame(SEL_ALIAS_Y, 10, 10, FILL_EXTREME, 0);
    // Degenerate sizes: zero width and height act as one.
    run_frame(rkc_pkg::SEL_SOBEL_X, 0, 0, FILL_RANDOM, 20);
    run_frame(rkc_pkg::SEL_CONTRAST, 10, 0, FILL_RANDOM, 0);

    // The receiver holds off long enough during this frame to fill the unit.
    hold_requests++;
    run_frame(rkc_pkg::SEL_SOBEL_X, 12, 10, FILL_RANDOM, 0);

    // Random small frames; the tail runs without any idling.
    while (random_pixels < 1250) begin
      w = $urandom_range(10, 18);
      h = $urandom_range(10, 14);
      if (random_pixels > 800) quiet = 1'b1;
      run_frame(2'($urandom_range(0, 3)), w, h,
                fill_t'($urandom_range(0, 3) == 0 ? FILL_EXTREME : FILL_RANDOM), 0);
      random_pixels += w * h;
    end

    // An oversized height saturates; only the first rows of the frame are sent.
    run_frame(rkc_pkg::SEL_SOBEL_Y, 10, 8191, FILL_RANDOM, 150);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
